// File: rtl/rle565_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 run-length encoder package
// Shared payload types and constants for the encoder and its result queue.
// ----------------------------------------------------------------------------
package rle565_pkg;

   localparam int unsigned RunLenWidth = 16;
   localparam int unsigned PixelWidth  = 16;
   localparam int unsigned ChanWidth   = 8;

   localparam logic [RunLenWidth-1:0] RunMax = 16'hFFFF;

   // Result queue geometry.
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [ChanWidth-1:0] chan_a;
      logic [ChanWidth-1:0] chan_b;
      logic [ChanWidth-1:0] chan_c;
      logic                 end_of_stream;
   } req_word_type;

   typedef struct packed {
      logic [RunLenWidth-1:0] run_length;
      logic [PixelWidth-1:0]  run_pixel;
      logic                   final_run;
   } rsp_word_type;

   // Push controls into the result queue. The second word is only pushed
   // together with the first.
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

// File: rtl/rle565_rq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 RLE result queue
// Small queue that takes up to two result words per cycle and returns one.
// ----------------------------------------------------------------------------
module rle565_rq (
   input  logic                   clock,
   input  logic                   reset,
   input  rle565_pkg::push_type     push,
   input  rle565_pkg::rsp_word_type push_word0,
   input  rle565_pkg::rsp_word_type push_word1,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rle565_pkg::rsp_word_type rsp_data
);
   import rle565_pkg::*;

   rsp_word_type           store_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic [QueuePtrW-1:0]   wr_ptr_next;
   logic                   pop;

   assign wr_ptr_next = wr_ptr_ff + QueuePtrW'(1);
   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = (count_ff != '0);
   assign rsp_data    = store_ff[rd_ptr_ff];
   // Two free entries are needed before another pixel may be processed.
   assign room        = (count_ff <= QueueCntW'(QueueDepth - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.first && push.second) begin
         wr_ptr_in = wr_ptr_ff + QueuePtrW'(2);
      end else if (push.first) begin
         wr_ptr_in = wr_ptr_next;
      end
      rd_ptr_in = pop ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + QueueCntW'(push.first) + QueueCntW'(push.second)
                  - QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         store_ff[wr_ptr_ff] <= push_word0;
      end
      if (push.second) begin
         store_ff[wr_ptr_next] <= push_word1;
      end
   end

endmodule

// File: rtl/rgb565_rle_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 run-length encoder
// Packs 24-bit pixels to 565 and emits (length, colour) runs.
// ----------------------------------------------------------------------------
// The encoder takes one pixel word per clock while the result queue has room.
// A pixel is held in an input register; from there it is packed to 565,
// compared with the open run and the run state is updated in the same cycle,
// while any finished runs are written into a four-entry result queue that
// drives the rsp port. A result word passes through the input register and
// the result queue before it can be taken from rsp.
// A pixel usually yields zero or one result word; a pixel that ends the
// stream and also closes the previous run yields two words, which leave the
// queue one per clock, so sustained throughput is one pixel per clock as long
// as the output side takes one word per clock. The input register moves on
// only when the queue has two free entries, so a stalled output side backs
// up into req_ready after a few words. The csr port writes the swap_mode bit
// (0: R5 G6 B5, 1: G5 R6 B5) and is always ready; it must only be written
// while the encoder is idle.
// ----------------------------------------------------------------------------
module rgb565_rle_encoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rle565_pkg::req_word_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rle565_pkg::rsp_word_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);
   import rle565_pkg::*;

   // Configuration.
   logic                   swap_mode_ff, swap_mode_in;

   // Input register.
   logic                   in_valid_ff, in_valid_in;
   req_word_type           in_word_ff;

   // Open run.
   logic [PixelWidth-1:0]  held_color_ff, held_color_in;
   logic [RunLenWidth-1:0] held_len_ff, held_len_in;

   // Processing stage.
   logic                   room;
   logic                   advance;
   logic [PixelWidth-1:0]  color;
   logic                   extend;
   logic                   close_run;
   logic [PixelWidth-1:0]  new_color;
   logic [RunLenWidth-1:0] new_len;
   push_type               push;
   rsp_word_type           word0;
   rsp_word_type           word1;

   assign csr_ready    = 1'b1;
   assign swap_mode_in = (csr_valid && csr_ready) ? csr_data : swap_mode_ff;

   // The held pixel is consumed when the queue can take two words.
   assign advance     = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_comb begin
      if (swap_mode_ff) begin
         color = {in_word_ff.chan_b[7:3], in_word_ff.chan_a[7:2], in_word_ff.chan_c[7:3]};
      end else begin
         color = {in_word_ff.chan_a[7:3], in_word_ff.chan_b[7:2], in_word_ff.chan_c[7:3]};
      end
   end

   // A run grows while the colour matches and it has not reached its limit.
   assign extend    = (held_len_ff != '0) && (color == held_color_ff) && (held_len_ff != RunMax);
   assign close_run = !extend && (held_len_ff != '0);
   assign new_len   = extend ? held_len_ff + RunLenWidth'(1) : RunLenWidth'(1);
   assign new_color = extend ? held_color_ff : color;

   always_comb begin
      word1.run_length = new_len;
      word1.run_pixel  = new_color;
      word1.final_run  = 1'b1;
      if (close_run) begin
         word0.run_length = held_len_ff;
         word0.run_pixel  = held_color_ff;
         word0.final_run  = 1'b0;
      end else begin
         word0 = word1;
      end
      push.first  = advance && (close_run || in_word_ff.end_of_stream);
      push.second = advance && close_run && in_word_ff.end_of_stream;

      held_len_in   = held_len_ff;
      held_color_in = held_color_ff;
      if (advance) begin
         if (in_word_ff.end_of_stream) begin
            held_len_in   = '0;
            held_color_in = '0;
         end else begin
            held_len_in   = new_len;
            held_color_in = new_color;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_mode_ff  <= 1'b0;
         in_valid_ff   <= 1'b0;
         held_len_ff   <= '0;
         held_color_ff <= '0;
      end else begin
         swap_mode_ff  <= swap_mode_in;
         in_valid_ff   <= in_valid_in;
         held_len_ff   <= held_len_in;
         held_color_ff <= held_color_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_word_ff <= req_data;
      end
   end

   rle565_rq u_rq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word0 (word0),
      .push_word1 (word1),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // An end-of-stream pixel always leaves the run state empty.
   a_eos_empties: assert property (@(posedge clock) disable iff (reset)
      (advance && in_word_ff.end_of_stream) |=> (held_len_ff == '0))
      else $error("run state not emptied after end of stream");

   // Any other pixel leaves an open run behind.
   a_run_open: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_word_ff.end_of_stream) |=> (held_len_ff != '0))
      else $error("no open run after a pixel");

   // With no open run the held colour is the empty value.
   a_empty_color: assert property (@(posedge clock) disable iff (reset)
      (held_len_ff == '0) |-> (held_color_ff == '0))
      else $error("held colour set without an open run");

   // The second word is only written together with the first.
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.second |-> (push.first && word0.final_run == 1'b0))
      else $error("second result word pushed out of order");

endmodule

// File: verif/tb_rgb565_rle_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 run-length encoder testbench
// Streams pixel words into the encoder under varying back-pressure, predicts
// every (length, colour) run word it should emit and checks them in order.
// ----------------------------------------------------------------------------
// Pixel words are queued by the stimulus process and handed to the request
// channel by a driver that inserts random gaps. A monitor on the rising edge
// runs each accepted pixel through a local run-length predictor and compares
// every accepted result word, field by field, with the oldest prediction.
// The swap_mode bit is written only while the encoder is drained, but runs are
// deliberately left open across those writes.
// ----------------------------------------------------------------------------
module tb_rgb565_rle_encoder;
   import rle565_pkg::*;

   // A cycle with no accepted word on any channel counts toward the watchdog.
   // The longest legal quiet stretch is the deliberate output hold-off.
   localparam int unsigned StallLimit    = 1000;
   localparam int unsigned HoldOffCycles = 300;
   localparam int unsigned SettleCycles  = 8;
   localparam int unsigned ReportLimit   = 10;
   localparam int unsigned RandomPixels  = 450;

   // swap_mode settings.
   localparam logic SwapOff = 1'b0;   // R5 G6 B5
   localparam logic SwapOn  = 1'b1;   // G5 R6 B5

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_data  = 1'b0;

   // Predictor state: the configured layout and the run that is still open.
   logic                   model_swap  = SwapOff;
   logic [PixelWidth-1:0]  open_color  = '0;
   logic [RunLenWidth-1:0] open_length = '0;

   req_word_type pixel_queue[$];
   rsp_word_type run_expect[$];

   int unsigned pixels_queued  = 0;
   int unsigned pixels_taken   = 0;
   int unsigned runs_checked   = 0;
   int unsigned fail_count     = 0;
   int unsigned csr_writes     = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned sender_gap_pct = 0;
   int unsigned sink_stall_pct = 0;
   int unsigned hold_left      = 0;
   logic        hold_ask       = 1'b0;
   logic        hold_seen      = 1'b0;
   logic        req_took       = 1'b0;
   logic        stim_swap      = SwapOff;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rgb565_rle_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Packs a 24-bit pixel to 565 in the selected layout. The dropped low bits
   // of each channel are what lets differently coded pixels share one run.
   function automatic logic [PixelWidth-1:0] pack_565(input logic swap,
                                                      input req_word_type px);
      if (swap) begin
         return {px.chan_b[7:3], px.chan_a[7:2], px.chan_c[7:3]};
      end
      return {px.chan_a[7:3], px.chan_b[7:2], px.chan_c[7:3]};
   endfunction

   function automatic req_word_type pixel(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic eos);
      return {a, b, c, eos};
   endfunction

   task automatic expect_run(input logic [RunLenWidth-1:0] len,
                             input logic [PixelWidth-1:0] color, input logic last);
      rsp_word_type w;
      w.run_length = len;
      w.run_pixel  = color;
      w.final_run  = last;
      run_expect.push_back(w);
   endtask

   // Run-length prediction for one accepted pixel word. A full run is closed
   // even when the next pixel has the same colour; an end-of-stream pixel is
   // first taken into the run and then flushes it, so it may close two runs.
   task automatic encode_pixel(input req_word_type px);
      logic [PixelWidth-1:0] color;
      color = pack_565(model_swap, px);
      if (open_length != 0 && color == open_color && open_length != RunMax) begin
         open_length = open_length + 1'b1;
      end else begin
         if (open_length != 0) begin
            expect_run(open_length, open_color, 1'b0);
         end
         open_color  = color;
         open_length = RunLenWidth'(1);
      end
      if (px.end_of_stream) begin
         expect_run(open_length, open_color, 1'b1);
         open_color  = '0;
         open_length = '0;
      end
   endtask

   // The monitor samples all handshakes on the rising edge. Pixels accepted
   // here cannot produce a result word at the same edge, since the encoder
   // registers its input first, so predicting before checking is safe.
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      req_took = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_took = 1'b1;
            encode_pixel(req_data);
            pixels_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            runs_checked++;
            if (run_expect.size() == 0) begin
               if (fail_count < ReportLimit) begin
                  $display("[%0t] unexpected run word: length %0d pixel %h final %b",
                           $realtime, rsp_data.run_length, rsp_data.run_pixel,
                           rsp_data.final_run);
               end
               fail_count++;
            end else begin
               want = run_expect.pop_front();
               if (rsp_data.run_length !== want.run_length ||
                   rsp_data.run_pixel !== want.run_pixel ||
                   rsp_data.final_run !== want.final_run) begin
                  if (fail_count < ReportLimit) begin
                     $display("[%0t] run word %0d: expected length %0d pixel %h final %b,",
                              $realtime, runs_checked, want.run_length, want.run_pixel,
                              want.final_run);
                     $display("   got length %0d pixel %h final %b",
                              rsp_data.run_length, rsp_data.run_pixel, rsp_data.final_run);
                  end
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            model_swap = csr_data;
            csr_writes++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= StallLimit) begin
            $display("Watchdog: no word moved for %0d cycles, %0d pixels and %0d runs pending",
                     StallLimit, pixels_queued - pixels_taken, run_expect.size());
            $display("rgb565_rle_encoder: mismatch");
            $finish;
         end
      end
   end

   // The pixel driver presents the next queued word on the falling edge, or
   // idles instead. A word stays on the bus until the monitor saw it taken.
   always @(negedge clock) begin : pixel_driver
      if (!reset && (!req_valid || req_took)) begin
         if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
            req_data  <= pixel_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The result sink stalls at random. On request it holds rsp_ready low for a
   // long stretch so that the result queue fills and req_ready drops.
   always @(negedge clock) begin : result_sink
      if (hold_ask && !hold_seen) begin
         hold_seen = 1'b1;
         hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   task automatic offer_pixel(input req_word_type px);
      pixel_queue.push_back(px);
      pixels_queued++;
   endtask

   task automatic write_swap(input logic mode);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
      stim_swap = mode;
   endtask

   // Waits until every queued pixel is taken and every predicted run word has
   // arrived. A pixel that only extends a run may still sit in the input
   // register then, so a settling wait follows before anything is reconfigured.
   task automatic settle();
      do @(negedge clock);
      while (pixels_taken != pixels_queued || run_expect.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Random stimulus is mostly runs of one packed colour whose dropped low bits
   // vary, so that runs really grow; some runs are cut by an end-of-stream word
   // and one pick in ten is a single unrelated noise word.
   task automatic queue_random(input int unsigned count);
      req_word_type base;
      req_word_type px;
      int unsigned  run_len;
      int unsigned  cut;
      int unsigned  n;
      int unsigned  i;
      n = 0;
      while (n < count) begin
         base = req_word_type'($urandom);
         if ($urandom_range(9) == 0) begin
            base.end_of_stream = ($urandom_range(3) == 0);
            offer_pixel(base);
            n++;
         end else begin
            if ($urandom_range(7) == 0) base.chan_a = $urandom_range(1) ? 8'hFF : 8'h00;
            if ($urandom_range(7) == 0) base.chan_b = $urandom_range(1) ? 8'hFF : 8'h00;
            if ($urandom_range(7) == 0) base.chan_c = $urandom_range(1) ? 8'hFF : 8'h00;
            run_len = ($urandom_range(3) == 0) ? $urandom_range(40, 2) : $urandom_range(6, 1);
            cut = ($urandom_range(7) == 0) ? $urandom_range(run_len - 1) : run_len;
            for (i = 0; i < run_len; i++) begin
               px = base;
               px.chan_a[1:0] = 2'($urandom);
               px.chan_b[1:0] = 2'($urandom);
               px.chan_c[2:0] = 3'($urandom);
               if (stim_swap) begin
                  px.chan_b[2] = 1'($urandom);
               end else begin
                  px.chan_a[2] = 1'($urandom);
               end
               px.end_of_stream = (i == cut) ||
                                  (i == run_len - 1 && $urandom_range(4) == 0);
               offer_pixel(px);
               n++;
            end
         end
      end
   endtask

   initial begin : stimulus
      req_word_type px;
      int unsigned  k;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words in the standard layout, with the sender and the sink both
      // idling. Black first checks that the cleared state is not an open run.
      sender_gap_pct = 30;
      sink_stall_pct = 51;
      write_swap(SwapOff);
      repeat (3) offer_pixel(pixel(8'h00, 8'h00, 8'h00, 1'b0));
      offer_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
      offer_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
      // A lone end-of-stream pixel with nothing open flushes a run of one.
      offer_pixel(pixel(8'h12, 8'h34, 8'h56, 1'b1));
      // Same packed colour from different bytes, then an end-of-stream pixel of
      // a new colour: the closed run and the new one both come out.
      offer_pixel(pixel(8'h80, 8'h40, 8'h20, 1'b0));
      offer_pixel(pixel(8'h87, 8'h43, 8'h27, 1'b0));
      offer_pixel(pixel(8'h10, 8'h20, 8'h30, 1'b1));
      offer_pixel(pixel(8'hF8, 8'h00, 8'h00, 1'b0));
      offer_pixel(pixel(8'h00, 8'hFC, 8'h00, 1'b0));
      offer_pixel(pixel(8'h00, 8'h00, 8'hF8, 1'b0));
      // Equal red and green pack alike in both layouts; this run stays open
      // across the layout change and has to go on growing after it.
      offer_pixel(pixel(8'h84, 8'h84, 8'h10, 1'b0));
      offer_pixel(pixel(8'h84, 8'h84, 8'h10, 1'b0));
      settle();

      write_swap(SwapOn);
      offer_pixel(pixel(8'h84, 8'h84, 8'h13, 1'b0));
      offer_pixel(pixel(8'h84, 8'h84, 8'h10, 1'b1));
      offer_pixel(pixel(8'h80, 8'h40, 8'h20, 1'b0));
      offer_pixel(pixel(8'h40, 8'h80, 8'h20, 1'b0));
      offer_pixel(pixel(8'h43, 8'h87, 8'h27, 1'b0));
      offer_pixel(pixel(8'hFF, 8'h00, 8'hFF, 1'b1));
      offer_pixel(pixel(8'h00, 8'hFF, 8'h00, 1'b0));
      settle();

      // Random runs, first with the sink stalling more than the sender idles,
      // then the other way round.
      write_swap(SwapOff);
      queue_random(RandomPixels);
      settle();

      sender_gap_pct = 51;
      sink_stall_pct = 30;
      write_swap(SwapOn);
      queue_random(RandomPixels);
      settle();

      // One run of the full 65535 pixels without idling. The next pixel of the
      // same colour ends the stream, so it must start a run of its own.
      sender_gap_pct = 0;
      sink_stall_pct = 0;
      px = pixel(8'h55, 8'hAA, 8'h33, 1'b0);
      for (k = 0; k < RunMax; k++) begin
         px.chan_c[2:0] = 3'($urandom);
         offer_pixel(px);
      end
      px.end_of_stream = 1'b1;
      offer_pixel(px);
      settle();

      // No idling at all, except one long hold-off of the sink while pixels
      // keep coming, so the encoder has to back up into req_ready.
      write_swap(SwapOff);
      hold_ask = 1'b1;
      queue_random(RandomPixels);
      settle();

      $display("Checked %0d run words from %0d pixel words across %0d swap_mode writes,",
               runs_checked, pixels_taken, csr_writes);
      $display("with both layouts, a full-length run, stream flushes and a long sink stall.");
      if (fail_count == 0 && run_expect.size() == 0) begin
         $display("rgb565_rle_encoder: match");
      end else begin
         $display("rgb565_rle_encoder: mismatch");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/rle565_pkg.sv
rtl/rle565_rq.sv
rtl/rgb565_rle_encoder.sv
verif/tb_rgb565_rle_encoder.sv
